[design/sps_pkg.sv]
// Shared widths, codes and control structs for the step period to pulse symbol block.
package sps_pkg;

    localparam int OP_W     = 2;
    localparam int PERIOD_W = 21;
    localparam int FRAC_W   = 16;
    localparam int PW_W     = 12;
    localparam int DUR_W    = 15;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam int MAX_DURATION_DEF = 32767;
    localparam int PERIOD_BITS_DEF  = 21;

    localparam logic [PW_W-1:0] PW_RESET = 12'd10;

    localparam logic [REG_IDX_W-1:0] REG_PULSE_WIDTH = 1'b0;

    localparam logic [OP_W-1:0] OP_STEP = 2'd0;
    localparam logic [OP_W-1:0] OP_LAST = 2'd1;
    localparam logic [OP_W-1:0] OP_END  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic load;
        logic clamp;
        logic sub;
        logic cap;
        logic emit_first;
        logic emit_fill;
        logic emit_term;
        logic last;
    } sps_cmd_t;

    typedef struct packed {
        logic out_free;
        logic first_ends;
        logic fill_ends;
    } sps_status_t;

endpackage

[design/sps_if.sv]
// Valid/ready stream interfaces for step requests and pulse symbols.
interface step_in_if
    import sps_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [PERIOD_W-1:0] period_ticks;
    logic [FRAC_W-1:0]   period_fraction;

    modport source (output valid, output opcode, output period_ticks,
                    output period_fraction, input ready);
    modport sink   (input valid, input opcode, input period_ticks,
                    input period_fraction, output ready);
endinterface

interface symbol_out_if
    import sps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             first_level;
    logic [DUR_W-1:0] first_duration;
    logic             second_level;
    logic [DUR_W-1:0] second_duration;
    logic             last_of_run;

    modport source (output valid, output first_level, output first_duration,
                    output second_level, output second_duration,
                    output last_of_run, input ready);
    modport sink   (input valid, input first_level, input first_duration,
                    input second_level, input second_duration,
                    input last_of_run, output ready);
endinterface

[design/sps_datapath.sv]
// Datapath: fraction accumulator, period clamp, remaining time and output symbol register.
module sps_datapath
    import sps_pkg::*;
#(
    parameter int MAX_DURATION = MAX_DURATION_DEF,
    parameter int PERIOD_BITS  = PERIOD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [PW_W-1:0]     pulse_width,
    input  logic [PERIOD_W-1:0] period_ticks,
    input  logic [FRAC_W-1:0]   period_fraction,
    input  sps_cmd_t            cmd,
    output sps_status_t         status,
    symbol_out_if.source        symbol_out
);

    localparam int CALC_W = (PERIOD_BITS + 1 > 23) ? PERIOD_BITS + 1 : 23;
    localparam logic [CALC_W-1:0] CAP_TICKS = CALC_W'((64'd1 << PERIOD_BITS) - 64'd1);
    localparam logic [CALC_W-1:0] CAP_REM   = CALC_W'(125 * MAX_DURATION);
    localparam logic [CALC_W-1:0] MAXD      = CALC_W'(MAX_DURATION);
    localparam logic [CALC_W-1:0] MAXD2     = CALC_W'(2 * MAX_DURATION);

    logic [FRAC_W-1:0] acc_reg, acc_next;
    logic [CALC_W-1:0] ticks_reg, ticks_next;
    logic [CALC_W-1:0] rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;
    logic              l0_reg, l0_next;
    logic [DUR_W-1:0]  d0_reg, d0_next;
    logic              l1_reg, l1_next;
    logic [DUR_W-1:0]  d1_reg, d1_next;
    logic              last_reg, last_next;

    logic [FRAC_W:0]   frac_sum;
    logic [CALC_W-1:0] pw_wide;
    logic [CALC_W-1:0] half;
    logic [CALC_W-1:0] half_rest;
    logic              first_ends;
    logic              fill_ends;

    assign frac_sum   = {1'b0, acc_reg} + {1'b0, period_fraction};
    assign pw_wide    = CALC_W'(pulse_width);
    assign half       = rem_reg >> 1;
    assign half_rest  = rem_reg - half;
    assign first_ends = (rem_reg <= MAXD);
    assign fill_ends  = (rem_reg <= MAXD2);

    assign status.out_free   = !out_valid_reg || symbol_out.ready;
    assign status.first_ends = first_ends;
    assign status.fill_ends  = fill_ends;

    always_comb
    begin
        acc_next       = acc_reg;
        ticks_next     = ticks_reg;
        rem_next       = rem_reg;
        out_valid_next = symbol_out.ready ? 1'b0 : out_valid_reg;
        l0_next        = l0_reg;
        d0_next        = d0_reg;
        l1_next        = l1_reg;
        d1_next        = d1_reg;
        last_next      = last_reg;

        if (cmd.load)
        begin
            acc_next   = frac_sum[FRAC_W-1:0];
            ticks_next = CALC_W'(period_ticks) + CALC_W'(frac_sum[FRAC_W]);
        end
        if (cmd.clamp && (ticks_reg > CAP_TICKS))
        begin
            ticks_next = CAP_TICKS;
        end
        if (cmd.sub)
        begin
            rem_next = (ticks_reg > pw_wide) ? (ticks_reg - pw_wide) : CALC_W'(1);
        end
        if (cmd.cap && (rem_reg > CAP_REM))
        begin
            rem_next = CAP_REM;
        end
        if (cmd.emit_first)
        begin
            out_valid_next = 1'b1;
            l0_next        = 1'b1;
            d0_next        = DUR_W'(pulse_width);
            l1_next        = 1'b0;
            d1_next        = first_ends ? rem_reg[DUR_W-1:0] : MAXD[DUR_W-1:0];
            last_next      = cmd.last;
            rem_next       = rem_reg - MAXD;
        end
        if (cmd.emit_fill)
        begin
            out_valid_next = 1'b1;
            l0_next        = 1'b0;
            l1_next        = 1'b0;
            d0_next        = fill_ends ? half[DUR_W-1:0] : MAXD[DUR_W-1:0];
            d1_next        = fill_ends ? half_rest[DUR_W-1:0] : MAXD[DUR_W-1:0];
            last_next      = cmd.last;
            rem_next       = rem_reg - MAXD2;
        end
        if (cmd.emit_term)
        begin
            out_valid_next = 1'b1;
            l0_next        = 1'b0;
            d0_next        = '0;
            l1_next        = 1'b0;
            d1_next        = '0;
            last_next      = 1'b1;
            acc_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ticks_reg <= ticks_next;
        rem_reg   <= rem_next;
        l0_reg    <= l0_next;
        d0_reg    <= d0_next;
        l1_reg    <= l1_next;
        d1_reg    <= d1_next;
        last_reg  <= last_next;
    end

    assign symbol_out.valid           = out_valid_reg;
    assign symbol_out.first_level     = l0_reg;
    assign symbol_out.first_duration  = d0_reg;
    assign symbol_out.second_level    = l1_reg;
    assign symbol_out.second_duration = d1_reg;
    assign symbol_out.last_of_run     = last_reg;

`ifndef ASSERT_OFF
    a_fill_leaves_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_fill && !fill_ends) |=> (rem_reg != '0))
        else $error("fill symbol left no remaining time");

    a_cap_bounds_rem: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap |=> (rem_reg <= CAP_REM) && (rem_reg != '0))
        else $error("remaining time out of range after cap");
`endif

endmodule

[design/sps_ctrl.sv]
// Controller: sequences load, clamp and symbol emission for each step request.
module sps_ctrl
    import sps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] opcode,
    output logic            in_ready,
    input  sps_status_t     status,
    output sps_cmd_t        cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLAMP = 7'b0000010,
        S_SUB   = 7'b0000100,
        S_CAP   = 7'b0001000,
        S_FIRST = 7'b0010000,
        S_FILL  = 7'b0100000,
        S_TERM  = 7'b1000000
    } sps_state_t;

    sps_state_t state_reg, state_next;
    logic       last_op_reg, last_op_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_ready && in_valid;

    always_comb
    begin
        state_next   = state_reg;
        last_op_next = last_op_reg;
        cmd          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_STEP, OP_LAST:
                        begin
                            cmd.load     = 1'b1;
                            last_op_next = (opcode == OP_LAST);
                            state_next   = S_CLAMP;
                        end
                        OP_END:
                        begin
                            state_next = S_TERM;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                cmd.cap    = 1'b1;
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                if (status.out_free)
                begin
                    cmd.emit_first = 1'b1;
                    cmd.last       = status.first_ends && !last_op_reg;
                    if (status.first_ends)
                    begin
                        state_next = last_op_reg ? S_TERM : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_fill = 1'b1;
                    cmd.last      = status.fill_ends && !last_op_reg;
                    if (status.fill_ends)
                    begin
                        state_next = last_op_reg ? S_TERM : S_IDLE;
                    end
                end
            end
            S_TERM:
            begin
                if (status.out_free)
                begin
                    cmd.emit_term = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            last_op_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            last_op_reg <= last_op_next;
        end
    end

`ifndef ASSERT_OFF
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_first, cmd.emit_fill, cmd.emit_term}))
        else $error("more than one symbol emitted in a cycle");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_first || cmd.emit_fill || cmd.emit_term) |-> status.out_free)
        else $error("symbol emitted into an occupied output register");

    a_end_goes_term: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_END)) |=> (state_reg == S_TERM))
        else $error("end of move did not lead to a terminator");

    a_none_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_NONE)) |=> (state_reg == S_IDLE))
        else $error("unused opcode started work");
`endif

endmodule

[design/step_period_to_pulse_symbols.sv]
// Top level: configuration registers, controller and datapath of the step period to pulse symbol block.
// A step request is accepted only in idle; it then passes the clamp, subtract and cap states, and
// the first symbol is registered in the first-symbol state once the output register is free. A new
// request is taken only after the controller is back in idle, when the first symbol, any fill symbols
// and any terminator are out; the controller sequence and the single output register set this pace.
// Reset: asynchronous active low; clears the accumulator, control state and output valid,
// and loads the pulse width register with 10.
module step_period_to_pulse_symbols
    import sps_pkg::*;
#(
    parameter int MAX_DURATION = MAX_DURATION_DEF,
    parameter int PERIOD_BITS  = PERIOD_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    step_in_if.sink           step_in,
    symbol_out_if.source      symbol_out
);

    logic [PW_W-1:0]      pw_reg, pw_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    sps_cmd_t             cmd;
    sps_status_t          status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        pw_next = pw_reg;
        if (cfg_write && (reg_idx == REG_PULSE_WIDTH))
        begin
            pw_next = pwdata[PW_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_PULSE_WIDTH) ? DATA_W'(pw_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= PW_RESET;
        end
        else
        begin
            pw_reg <= pw_next;
        end
    end

    sps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (step_in.valid),
        .opcode   (step_in.opcode),
        .in_ready (step_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sps_datapath #(
        .MAX_DURATION (MAX_DURATION),
        .PERIOD_BITS  (PERIOD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .pulse_width     (pw_reg),
        .period_ticks    (step_in.period_ticks),
        .period_fraction (step_in.period_fraction),
        .cmd             (cmd),
        .status          (status),
        .symbol_out      (symbol_out)
    );

endmodule

[dv/tb_step_period_to_pulse_symbols.sv]
`timescale 1ns / 100ps
// Self-checking testbench for step_period_to_pulse_symbols: steps in, predicted pulse symbols out.
module tb_step_period_to_pulse_symbols;
    import sps_pkg::*;

    localparam int MAX_DUR       = MAX_DURATION_DEF;
    localparam int PERIOD_MAX    = (1 << PERIOD_BITS_DEF) - 1;
    localparam int SYMBOL_CAP    = 63;
    localparam int SETTLE_CYCLES = 16;
    localparam int STEPS_PER_PHASE = 20;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;

    typedef struct packed {
        logic             first_level;
        logic [DUR_W-1:0] first_duration;
        logic             second_level;
        logic [DUR_W-1:0] second_duration;
        logic             last_of_run;
    } symbol_t;

    localparam symbol_t TERMINATOR = {1'b0, {DUR_W{1'b0}}, 1'b0, {DUR_W{1'b0}}, 1'b1};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    step_in_if    step_in();
    symbol_out_if symbol_out();

    step_period_to_pulse_symbols DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .step_in    (step_in),
        .symbol_out (symbol_out)
    );

    logic [PW_W-1:0]   pulse_width;
    logic [FRAC_W-1:0] frac_acc;
    symbol_t           pending_symbols[$];
    int                mismatch_count = 0;
    bit                gaps_enabled = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int gap_cycles();
        int r;
        if (!gaps_enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic void predict_symbols(logic [OP_W-1:0] op, logic [PERIOD_W-1:0] ticks,
                                            logic [FRAC_W-1:0] frac);
        logic [FRAC_W:0] acc_sum;
        int unsigned     pw;
        int unsigned     period;
        int unsigned     span;
        int unsigned     half;
        symbol_t         run[$];
        if (op == OP_NONE)
            return;
        if (op == OP_END)
        begin
            frac_acc = '0;
            pending_symbols.push_back(TERMINATOR);
            return;
        end
        pw = pulse_width;
        acc_sum = {1'b0, frac_acc} + {1'b0, frac};
        frac_acc = acc_sum[FRAC_W-1:0];
        period = ticks + acc_sum[FRAC_W];
        if (period > PERIOD_MAX)
            period = PERIOD_MAX;
        if (period > pw + 125 * MAX_DUR)
            period = pw + 125 * MAX_DUR;
        if (period < pw + 1)
            period = pw + 1;
        span = period - pw;
        if (span < MAX_DUR)
        begin
            run.push_back(symbol_t'({1'b1, DUR_W'(pw), 1'b0, DUR_W'(span), 1'b0}));
            span = 0;
        end
        else
        begin
            run.push_back(symbol_t'({1'b1, DUR_W'(pw), 1'b0, DUR_W'(MAX_DUR), 1'b0}));
            span -= MAX_DUR;
        end
        while (span > 0 && run.size() < SYMBOL_CAP)
        begin
            if (span < 2 * MAX_DUR)
            begin
                half = span >> 1;
                run.push_back(symbol_t'({1'b0, DUR_W'(half), 1'b0, DUR_W'(span - half), 1'b0}));
                span = 0;
            end
            else
            begin
                run.push_back(symbol_t'({1'b0, DUR_W'(MAX_DUR), 1'b0, DUR_W'(MAX_DUR), 1'b0}));
                span -= 2 * MAX_DUR;
            end
        end
        if (op == OP_LAST)
        begin
            frac_acc = '0;
            run.push_back(TERMINATOR);
        end
        else
            run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i])
            pending_symbols.push_back(run[i]);
    endfunction

    function automatic void check_field(string name, logic [DUR_W-1:0] want,
                                        logic [DUR_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Sink side: check each symbol transaction, then stall at random
    initial
    begin
        int      stall;
        symbol_t want;
        stall = 0;
        symbol_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && symbol_out.valid && symbol_out.ready)
            begin
                if (pending_symbols.size() == 0)
                begin
                    $error("symbol transaction with no expected symbol: %0d %0d %0d %0d %0d",
                           symbol_out.first_level, symbol_out.first_duration,
                           symbol_out.second_level, symbol_out.second_duration,
                           symbol_out.last_of_run);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_symbols.pop_front();
                    check_field("first_level", want.first_level, symbol_out.first_level);
                    check_field("first_duration", want.first_duration,
                                symbol_out.first_duration);
                    check_field("second_level", want.second_level, symbol_out.second_level);
                    check_field("second_duration", want.second_duration,
                                symbol_out.second_duration);
                    check_field("last_of_run", want.last_of_run, symbol_out.last_of_run);
                end
            end
            if (stall > 0)
            begin
                stall--;
                symbol_out.ready <= 1'b0;
            end
            else
            begin
                stall = gap_cycles();
                symbol_out.ready <= (stall == 0);
            end
        end
    end

    task automatic send_step(logic [OP_W-1:0] op, logic [PERIOD_W-1:0] ticks,
                             logic [FRAC_W-1:0] frac);
        int gap;
        step_in.valid           <= 1'b1;
        step_in.opcode          <= op;
        step_in.period_ticks    <= ticks;
        step_in.period_fraction <= frac;
        @(posedge clk);
        while (!step_in.ready)
            @(posedge clk);
        predict_symbols(op, ticks, frac);
        gap = gap_cycles();
        if (gap > 0)
        begin
            step_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write a register, then read it back
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PW_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_PULSE_WIDTH)
            pulse_width = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_PULSE_WIDTH && prdata[PW_W-1:0] !== pulse_width)
        begin
            $error("pulse_width_ticks: expected %0d, got %0d", pulse_width, prdata[PW_W-1:0]);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        step_in.valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PERIOD_W-1:0] random_period();
        int unsigned pw;
        int          r;
        pw = pulse_width;
        r = $urandom_range(0, 99);
        if (r < 50)
            return PERIOD_W'($urandom_range(0, pw + 3 * MAX_DUR));
        if (r < 75)
            return PERIOD_W'(pw + $urandom_range(0, 3) * MAX_DUR + $urandom_range(0, 2) - 1);
        if (r < 92)
            return PERIOD_W'($urandom_range(0, PERIOD_MAX));
        return PERIOD_W'(PERIOD_MAX - $urandom_range(0, 3));
    endfunction

    function automatic logic [FRAC_W-1:0] random_fraction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return FRAC_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic run_random_steps(int steps);
        int              sent;
        int              r;
        logic [OP_W-1:0] op;
        sent = 0;
        while (sent < steps)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                op = OP_STEP;
            else if (r < 82)
                op = OP_LAST;
            else if (r < 90)
                op = OP_END;
            else
                op = OP_NONE;
            send_step(op, random_period(), random_fraction());
            if (op != OP_NONE)
                sent++;
        end
    endtask

    task automatic test_default_width_steps();
        send_step(OP_STEP, '0, '0);
        send_step(OP_STEP, PERIOD_W'(100), 16'h8000);
        send_step(OP_STEP, PERIOD_W'(100), 16'h8000);
        send_step(OP_STEP, PERIOD_W'(pulse_width + MAX_DUR - 1), '0);
        send_step(OP_STEP, PERIOD_W'(pulse_width + MAX_DUR), '0);
        send_step(OP_STEP, PERIOD_W'(pulse_width + MAX_DUR + 1), '0);
        send_step(OP_STEP, PERIOD_W'(pulse_width + 3 * MAX_DUR - 1), '0);
        send_step(OP_STEP, PERIOD_W'(pulse_width + 3 * MAX_DUR), '0);
        send_step(OP_STEP, PERIOD_W'(PERIOD_MAX), '1);
        send_step(OP_STEP, PERIOD_W'(PERIOD_MAX), FRAC_W'(1));
        send_step(OP_LAST, PERIOD_W'(50), 16'h1234);
        send_step(OP_END, PERIOD_W'(12345), '1);
        send_step(OP_NONE, PERIOD_W'(PERIOD_MAX), '1);
        send_step(OP_STEP, PERIOD_W'(21'h155555), 16'hAAAA);
        send_step(OP_LAST, '0, '0);
        wait_idle();
    endtask

    task automatic test_unused_register();
        write_reg(REG_UNUSED, PW_W'(77));
        send_step(OP_STEP, '0, '0);
        wait_idle();
    endtask

    task automatic test_width_extremes();
        write_reg(REG_PULSE_WIDTH, '0);
        send_step(OP_STEP, '0, '0);
        send_step(OP_STEP, PERIOD_W'(MAX_DUR), '0);
        wait_idle();
        write_reg(REG_PULSE_WIDTH, '1);
        send_step(OP_STEP, '0, '0);
        send_step(OP_STEP, PERIOD_W'(PERIOD_MAX), '0);
        send_step(OP_LAST, PERIOD_W'(pulse_width + MAX_DUR + 1), '0);
        wait_idle();
        write_reg(REG_PULSE_WIDTH, PW_W'(1));
        send_step(OP_STEP, PERIOD_W'(2), '1);
        wait_idle();
    endtask

    task automatic test_random_settings();
        logic [PW_W-1:0] width;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 0)
                width = '0;
            else if (phase == 1)
                width = '1;
            else
                width = PW_W'($urandom_range(1, 4094));
            write_reg(REG_PULSE_WIDTH, width);
            run_random_steps(STEPS_PER_PHASE);
            wait_idle();
        end
    endtask

    task automatic test_back_to_back();
        write_reg(REG_PULSE_WIDTH, PW_RESET);
        gaps_enabled = 1'b0;
        run_random_steps(16);
        wait_idle();
        gaps_enabled = 1'b1;
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        step_in.valid           <= 1'b0;
        step_in.opcode          <= OP_STEP;
        step_in.period_ticks    <= '0;
        step_in.period_fraction <= '0;
        pulse_width = PW_RESET;
        frac_acc    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_width_steps();
        test_unused_register();
        test_width_extremes();
        test_random_settings();
        test_back_to_back();

        wait_idle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
design/sps_pkg.sv
design/sps_if.sv
design/sps_datapath.sv
design/sps_ctrl.sv
design/step_period_to_pulse_symbols.sv
dv/tb_step_period_to_pulse_symbols.sv
